// ===== rtl/crtc_pkg.sv =====
// Shared types and constants for the cartridge real-time clock.
// Holds the transaction kinds, bus region codes and clock register codes.
// No dependencies.
package crtc_pkg;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_READ  = 2'd2
   } req_kind_type;

   // Bus regions, decoded from address bits 15..13.
   localparam logic [2:0] REGION_ENABLE = 3'b000;
   localparam logic [2:0] REGION_SELECT = 3'b010;
   localparam logic [2:0] REGION_LATCH  = 3'b011;
   localparam logic [2:0] REGION_CLOCK  = 3'b101;

   localparam logic [3:0] ENABLE_KEY = 4'hA;
   localparam logic [7:0] LATCH_KEY  = 8'h01;

   // Clock register codes written to the register select.
   localparam logic [7:0] REG_SECONDS   = 8'h08;
   localparam logic [7:0] REG_MINUTES   = 8'h09;
   localparam logic [7:0] REG_HOURS     = 8'h0A;
   localparam logic [7:0] REG_DAYS_LOW  = 8'h0B;
   localparam logic [7:0] REG_DAYS_HIGH = 8'h0C;

   localparam logic [5:0] SECONDS_LAST = 6'd59;
   localparam logic [5:0] MINUTES_LAST = 6'd59;
   localparam logic [4:0] HOURS_LAST   = 5'd23;
   localparam logic [8:0] DAYS_LAST    = 9'd511;

   localparam logic [7:0] OPEN_BUS = 8'hFF;

endpackage

// ===== rtl/cartridge_real_time_clock.sv =====
// Cartridge real-time clock: live and latched time counters behind a bus.
// Depends on crtc_pkg for transaction kinds and register codes.
// Accepts one transaction per clock cycle and returns exactly one result for each,
// in order. An input register holds the transaction; when it advances, the
// transaction updates the clock state and loads the result register. The
// input side stalls only while both the input register and the result register
// are full and the result is not being taken, so with rsp_tready held high the
// block sustains one transaction every cycle.
module cartridge_real_time_clock (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] bus_address, [23:16] write_data
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] read_data
   output logic        rsp_tuser    // [0] read_valid
);

   // Input register.
   logic        stage_valid_ff, stage_valid_in;
   logic [1:0]  req_kind_ff, req_kind_in;
   logic [15:0] req_addr_ff, req_addr_in;
   logic [7:0]  req_data_ff, req_data_in;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic        rsp_flag_ff, rsp_flag_in;

   // Clock state.
   logic        access_enable_ff, access_enable_in;
   logic [7:0]  register_select_ff, register_select_in;
   logic        latch_last_ff, latch_last_in;
   logic [5:0]  live_seconds_ff, live_seconds_in;
   logic [5:0]  live_minutes_ff, live_minutes_in;
   logic [4:0]  live_hours_ff, live_hours_in;
   logic [8:0]  live_days_ff, live_days_in;
   logic        halt_ff, halt_in;
   logic        carry_ff, carry_in;
   logic [5:0]  snap_seconds_ff, snap_seconds_in;
   logic [5:0]  snap_minutes_ff, snap_minutes_in;
   logic [4:0]  snap_hours_ff, snap_hours_in;
   logic [7:0]  snap_days_high_ff, snap_days_high_in;
   logic [7:0]  snap_days_low_ff, snap_days_low_in;

   logic        stage_advance;
   logic        window_open;
   logic [2:0]  region;
   logic        is_write;
   logic        snap_take;
   logic        clock_write;

   assign stage_advance = stage_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready    = !stage_valid_ff || stage_advance;

   assign region      = req_addr_ff[15:13];
   assign window_open = access_enable_ff &&
                        (register_select_ff >= crtc_pkg::REG_SECONDS) &&
                        (register_select_ff <= crtc_pkg::REG_DAYS_HIGH);
   assign is_write    = stage_advance &&
                        (req_kind_ff == crtc_pkg::KIND_WRITE);
   assign snap_take   = is_write && (region == crtc_pkg::REGION_LATCH) &&
                        !latch_last_ff && (req_data_ff == crtc_pkg::LATCH_KEY);
   assign clock_write = is_write && (region == crtc_pkg::REGION_CLOCK) && window_open;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      req_kind_in    = req_kind_ff;
      req_addr_in    = req_addr_ff;
      req_data_in    = req_data_ff;
      if (req_tvalid && req_tready) begin
         stage_valid_in = 1'b1;
         req_kind_in    = req_tuser;
         req_addr_in    = req_tdata[15:0];
         req_data_in    = req_tdata[23:16];
      end else if (stage_advance) begin
         stage_valid_in = 1'b0;
      end
   end

   always_comb begin
      access_enable_in   = access_enable_ff;
      register_select_in = register_select_ff;
      latch_last_in      = latch_last_ff;
      live_seconds_in    = live_seconds_ff;
      live_minutes_in    = live_minutes_ff;
      live_hours_in      = live_hours_ff;
      live_days_in       = live_days_ff;
      halt_in            = halt_ff;
      carry_in           = carry_ff;
      snap_seconds_in    = snap_seconds_ff;
      snap_minutes_in    = snap_minutes_ff;
      snap_hours_in      = snap_hours_ff;
      snap_days_high_in  = snap_days_high_ff;
      snap_days_low_in   = snap_days_low_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_tready;
      rsp_data_in        = rsp_data_ff;
      rsp_flag_in        = rsp_flag_ff;

      if (stage_advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_flag_in  = 1'b0;
         case (req_kind_ff)
            crtc_pkg::KIND_TICK: begin
               // Counters written past their limit wrap at field width with no carry.
               if (!halt_ff) begin
                  if (live_seconds_ff != crtc_pkg::SECONDS_LAST) begin
                     live_seconds_in = live_seconds_ff + 6'd1;
                  end else begin
                     live_seconds_in = '0;
                     if (live_minutes_ff != crtc_pkg::MINUTES_LAST) begin
                        live_minutes_in = live_minutes_ff + 6'd1;
                     end else begin
                        live_minutes_in = '0;
                        if (live_hours_ff != crtc_pkg::HOURS_LAST) begin
                           live_hours_in = live_hours_ff + 5'd1;
                        end else begin
                           live_hours_in = '0;
                           live_days_in  = live_days_ff + 9'd1;
                           if (live_days_ff == crtc_pkg::DAYS_LAST) begin
                              carry_in = 1'b1;
                           end
                        end
                     end
                  end
               end
            end
            crtc_pkg::KIND_WRITE: begin
               unique case (region)
                  crtc_pkg::REGION_ENABLE: begin
                     access_enable_in = (req_data_ff[3:0] == crtc_pkg::ENABLE_KEY);
                  end
                  crtc_pkg::REGION_SELECT: begin
                     register_select_in = req_data_ff;
                  end
                  crtc_pkg::REGION_LATCH: begin
                     if (snap_take) begin
                        snap_seconds_in   = live_seconds_ff;
                        snap_minutes_in   = live_minutes_ff;
                        snap_hours_in     = live_hours_ff;
                        snap_days_low_in  = live_days_ff[7:0];
                        snap_days_high_in = {carry_ff, halt_ff, 5'b0, live_days_ff[8]};
                     end
                     latch_last_in = (req_data_ff != 8'h00);
                  end
                  crtc_pkg::REGION_CLOCK: begin
                     if (window_open) begin
                        unique case (register_select_ff)
                           crtc_pkg::REG_SECONDS:  live_seconds_in = req_data_ff[5:0];
                           crtc_pkg::REG_MINUTES:  live_minutes_in = req_data_ff[5:0];
                           crtc_pkg::REG_HOURS:    live_hours_in   = req_data_ff[4:0];
                           crtc_pkg::REG_DAYS_LOW: live_days_in[7:0] = req_data_ff;
                           crtc_pkg::REG_DAYS_HIGH: begin
                              live_days_in[8] = req_data_ff[0];
                              halt_in         = req_data_ff[6];
                              carry_in        = req_data_ff[7];
                           end
                           default: begin
                           end
                        endcase
                     end
                  end
                  default: begin
                  end
               endcase
            end
            crtc_pkg::KIND_READ: begin
               rsp_flag_in = 1'b1;
               rsp_data_in = crtc_pkg::OPEN_BUS;
               if ((region == crtc_pkg::REGION_CLOCK) && window_open) begin
                  unique case (register_select_ff)
                     crtc_pkg::REG_SECONDS:   rsp_data_in = {2'b0, snap_seconds_ff};
                     crtc_pkg::REG_MINUTES:   rsp_data_in = {2'b0, snap_minutes_ff};
                     crtc_pkg::REG_HOURS:     rsp_data_in = {3'b0, snap_hours_ff};
                     crtc_pkg::REG_DAYS_LOW:  rsp_data_in = snap_days_low_ff;
                     crtc_pkg::REG_DAYS_HIGH: rsp_data_in = snap_days_high_ff;
                     default:                 rsp_data_in = crtc_pkg::OPEN_BUS;
                  endcase
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff     <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         access_enable_ff   <= 1'b0;
         register_select_ff <= '0;
         latch_last_ff      <= 1'b1;
         live_seconds_ff    <= '0;
         live_minutes_ff    <= '0;
         live_hours_ff      <= '0;
         live_days_ff       <= '0;
         halt_ff            <= 1'b0;
         carry_ff           <= 1'b0;
         snap_seconds_ff    <= '0;
         snap_minutes_ff    <= '0;
         snap_hours_ff      <= '0;
         snap_days_high_ff  <= '0;
         snap_days_low_ff   <= '0;
      end else begin
         stage_valid_ff     <= stage_valid_in;
         rsp_valid_ff       <= rsp_valid_in;
         access_enable_ff   <= access_enable_in;
         register_select_ff <= register_select_in;
         latch_last_ff      <= latch_last_in;
         live_seconds_ff    <= live_seconds_in;
         live_minutes_ff    <= live_minutes_in;
         live_hours_ff      <= live_hours_in;
         live_days_ff       <= live_days_in;
         halt_ff            <= halt_in;
         carry_ff           <= carry_in;
         snap_seconds_ff    <= snap_seconds_in;
         snap_minutes_ff    <= snap_minutes_in;
         snap_hours_ff      <= snap_hours_in;
         snap_days_high_ff  <= snap_days_high_in;
         snap_days_low_ff   <= snap_days_low_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      req_kind_ff <= req_kind_in;
      req_addr_ff <= req_addr_in;
      req_data_ff <= req_data_in;
      rsp_data_ff <= rsp_data_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_flag_ff;

   // The input side stalls only when both stages are full and the result is held.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (stage_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("input stalled while a stage was free");

   // Only a read transaction produces nonzero result data.
   a_nonread_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == 8'h00))
      else $error("non-read result carries data");

   // The snapshot moves only on a completed latch sequence.
   a_snapshot_on_latch: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(snap_seconds_ff)) |-> $past(snap_take))
      else $error("snapshot changed without a latch sequence");

   // Ticks keep an in-range seconds counter in range.
   a_seconds_in_range: assert property (@(posedge clock) disable iff (reset)
      ((live_seconds_ff <= crtc_pkg::SECONDS_LAST) && !clock_write)
      |=> (live_seconds_ff <= crtc_pkg::SECONDS_LAST))
      else $error("seconds counter left its range on a tick");

endmodule
